/* sv/ppmc_pkg.sv */
// ppmc_pkg: shared types, register map, mode codes and packed-pixel constants
// for the pixel put-mode combiner.
// No dependencies; imported by every module of the block.
package ppmc_pkg;

	// configuration port geometry
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	// register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_PIXEL_SIZE  = 2'd0;
	localparam logic [1:0] REG_PUT_MODE    = 2'd1;
	localparam logic [1:0] REG_CONST_ALPHA = 2'd2;

	// pixel size codes; the unused code behaves as 32-bit
	localparam logic [1:0] PIX_8  = 2'd0;
	localparam logic [1:0] PIX_16 = 2'd1;
	localparam logic [1:0] PIX_32 = 2'd2;

	// put mode codes
	localparam logic [3:0] MODE_PSET   = 4'd0;
	localparam logic [3:0] MODE_PRESET = 4'd1;
	localparam logic [3:0] MODE_AND    = 4'd2;
	localparam logic [3:0] MODE_OR     = 4'd3;
	localparam logic [3:0] MODE_XOR    = 4'd4;
	localparam logic [3:0] MODE_TRANS  = 4'd5;
	localparam logic [3:0] MODE_ALPHA  = 4'd6;
	localparam logic [3:0] MODE_ADD    = 4'd7;
	localparam logic [3:0] MODE_BLEND  = 4'd8;

	// reset values of the registers
	localparam logic [1:0] RST_PIXEL_SIZE  = PIX_32;
	localparam logic [3:0] RST_PUT_MODE    = MODE_PSET;
	localparam logic [7:0] RST_CONST_ALPHA = 8'd255;

	// packed-pixel masks and keys
	localparam logic [31:0] KEY565    = 32'h0000_F81F;
	localparam logic [31:0] KEY888    = 32'h00FF_00FF;
	localparam logic [31:0] LANE_RB   = 32'h00FF_00FF;
	localparam logic [31:0] LANE_GA   = 32'hFF00_FF00;
	localparam logic [31:0] SPREAD565 = 32'h07C0_F81F;
	localparam logic [31:0] CARRY565  = 32'h0801_0020;
	localparam logic [31:0] LOW7      = 32'h7F7F_7F7F;
	localparam logic [31:0] HIGH1     = 32'h8080_8080;
	localparam logic [31:0] RGB24     = 32'h00FF_FFFF;
	localparam logic [31:0] G565      = 32'h0000_07E0;

	// configuration registers
	typedef struct packed {
		logic [1:0] pixel_size;
		logic [3:0] put_mode;
		logic [7:0] const_alpha;
	} cfg_t;

	// input transaction payload
	typedef struct packed {
		logic [31:0] source_pixel;
		logic [31:0] dest_pixel;
	} pix_in_t;

	// result transaction payload
	typedef struct packed {
		logic [31:0] result_pixel;
		logic        write_enable;
	} pix_out_t;

endpackage

/* sv/ppmc_apb_regs.sv */
// ppmc_apb_regs: APB-style configuration registers (pixel size, put mode,
// constant alpha) with read-back.
// Depends on ppmc_pkg.
module ppmc_apb_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ppmc_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [ppmc_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [ppmc_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready,
	output ppmc_pkg::cfg_t                        cfg
);
	import ppmc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_size  <= RST_PIXEL_SIZE;
			cfg_q.put_mode    <= RST_PUT_MODE;
			cfg_q.const_alpha <= RST_CONST_ALPHA;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PIXEL_SIZE:  cfg_q.pixel_size  <= pwdata[1:0];
				REG_PUT_MODE:    cfg_q.put_mode    <= pwdata[3:0];
				REG_CONST_ALPHA: cfg_q.const_alpha <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		unique case (reg_idx)
			REG_PIXEL_SIZE:  prdata = {30'd0, cfg_q.pixel_size};
			REG_PUT_MODE:    prdata = {28'd0, cfg_q.put_mode};
			REG_CONST_ALPHA: prdata = {24'd0, cfg_q.const_alpha};
			default:         prdata = '0;
		endcase
	end

	// a write lands in the addressed register
	a_wr_size: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && reg_idx == REG_PIXEL_SIZE |=> cfg_q.pixel_size == $past(pwdata[1:0]))
		else $error("pixel_size write lost");
	a_wr_mode: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && reg_idx == REG_PUT_MODE |=> cfg_q.put_mode == $past(pwdata[3:0]))
		else $error("put_mode write lost");
	a_no_wr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_en |=> $stable(cfg_q))
		else $error("config changed without a write");

endmodule

/* sv/ppmc_combine.sv */
// ppmc_combine: combinational raster-op / alpha-blend datapath for one
// source/destination pixel pair; two shared 32x9 lane multipliers.
// Depends on ppmc_pkg.
module ppmc_combine (
	input  ppmc_pkg::cfg_t    cfg,
	input  ppmc_pkg::pix_in_t operand,
	output ppmc_pkg::pix_out_t res
);
	import ppmc_pkg::*;

	logic [31:0] s, d, mask;
	logic [8:0]  a_px, a_bl, a_sum, mul_k;
	logic [5:0]  a5;
	logic [31:0] sp16, dp16;
	logic [31:0] mul_a0, mul_a1;
	logic [40:0] prod0, prod1;
	logic [31:0] p0, p1;
	logic [31:0] mix_px;
	logic [31:0] q16, sm16, ov16, ov16b, sat16, fold16, add16_px;
	logic [31:0] x32, h1, h2, sum32, h1o, t2n, dn, add32_px;
	logic [31:0] blend16_px;
	logic        key8, key16, key32;
	logic        is_16, is_32;

	assign s = operand.source_pixel;
	assign d = operand.dest_pixel;

	// width mask and size decode
	always_comb begin
		unique case (cfg.pixel_size)
			PIX_8:   mask = 32'h0000_00FF;
			PIX_16:  mask = 32'h0000_FFFF;
			default: mask = 32'hFFFF_FFFF;
		endcase
	end
	assign is_16 = (cfg.pixel_size == PIX_16);
	assign is_32 = (cfg.pixel_size != PIX_8) && (cfg.pixel_size != PIX_16);

	// alpha factors
	assign a_px  = {1'b0, s[31:24]} + 9'd1;
	assign a_bl  = {1'b0, cfg.const_alpha} + 9'd1;
	assign a_sum = {1'b0, cfg.const_alpha} + 9'd7;
	assign a5    = a_sum[8:3];

	// 565 spread across both halves of the word
	assign sp16 = ((s << 16) | s) & SPREAD565;
	assign dp16 = ((d << 16) | d) & SPREAD565;

	// colour key detection
	assign key8  = (s[7:0] == 8'd0);
	assign key16 = ({16'd0, s[15:0]} == KEY565);
	assign key32 = ((s & RGB24) == KEY888);

	// multiplier operand select
	always_comb begin
		if (cfg.put_mode == MODE_ADD && is_16) begin
			mul_a0 = sp16;
			mul_a1 = '0;
			mul_k  = {3'd0, a5};
		end else if (cfg.put_mode == MODE_ADD) begin
			mul_a0 = s & LANE_RB;
			mul_a1 = (s >> 8) & LANE_RB;
			mul_k  = {1'b0, cfg.const_alpha};
		end else if (cfg.put_mode == MODE_BLEND && is_16) begin
			mul_a0 = (s & KEY565) - (d & KEY565);
			mul_a1 = (s & G565) - (d & G565);
			mul_k  = {3'd0, a5};
		end else begin
			mul_a0 = (s & LANE_RB) - (d & LANE_RB);
			mul_a1 = ((s & LANE_GA) >> 8) - ((d & LANE_GA) >> 8);
			mul_k  = (cfg.put_mode == MODE_ALPHA) ? a_px : a_bl;
		end
	end

	// lane multipliers, products wrap at 32 bits
	assign prod0 = {9'd0, mul_a0} * {32'd0, mul_k};
	assign prod1 = {9'd0, mul_a1} * {32'd0, mul_k};
	assign p0    = prod0[31:0];
	assign p1    = prod1[31:0];

	// 32-bit alpha mix
	assign mix_px = (((d & LANE_RB) + (p0 >> 8)) & LANE_RB)
		| (((d & LANE_GA) + p1) & LANE_GA);

	// 16-bit saturating add
	assign q16      = (p0 >> 5) & SPREAD565;
	assign sm16     = q16 + dp16;
	assign ov16     = sm16 & CARRY565;
	assign ov16b    = ov16 - (ov16 >> 5);
	assign sat16    = (sm16 | ov16b) & SPREAD565;
	assign fold16   = sat16 | (sat16 >> 16);
	assign add16_px = {16'd0, fold16[15:0]};

	// 32-bit saturating add, per byte
	assign x32      = ((p0 >> 8) & LANE_RB) | (p1 & LANE_GA);
	assign h1       = x32 & HIGH1;
	assign h2       = d & HIGH1;
	assign sum32    = (x32 & LOW7) + (d & LOW7);
	assign h1o      = h1 | h2;
	assign t2n      = h1 & h2;
	assign dn       = h1o & sum32;
	assign add32_px = sum32 | ((((t2n | dn) >> 7) + LOW7) ^ LOW7) | h1o;

	// 16-bit constant-alpha blend
	assign blend16_px = (((d & KEY565) + (p0 >> 5)) & KEY565)
		| (((d & G565) + (p1 >> 5)) & G565);

	// mode select
	always_comb begin
		res.write_enable = 1'b1;
		res.result_pixel = d;
		unique case (cfg.put_mode)
			MODE_PSET:   res.result_pixel = s & mask;
			MODE_PRESET: res.result_pixel = ~s & mask;
			MODE_AND:    res.result_pixel = s & d & mask;
			MODE_OR:     res.result_pixel = (s | d) & mask;
			MODE_XOR:    res.result_pixel = (s ^ d) & mask;
			MODE_TRANS: begin
				priority if (cfg.pixel_size == PIX_8) begin
					res.result_pixel = s & mask;
					res.write_enable = !key8;
				end else if (is_16) begin
					res.result_pixel = {16'd0, s[15:0]};
					res.write_enable = !key16;
				end else begin
					res.result_pixel = s & RGB24;
					res.write_enable = !key32;
				end
			end
			MODE_ALPHA: begin
				res.result_pixel = is_32 ? mix_px : (s & mask);
			end
			MODE_ADD: begin
				priority if (cfg.pixel_size == PIX_8) begin
					res.result_pixel = (s | d) & mask;
				end else if (is_16) begin
					res.write_enable = !key16;
					res.result_pixel = key16 ? d : add16_px;
				end else begin
					res.write_enable = !key32;
					res.result_pixel = key32 ? d : add32_px;
				end
			end
			MODE_BLEND: begin
				priority if (cfg.const_alpha == 8'd0) begin
					res.write_enable = 1'b0;
					res.result_pixel = d;
				end else if (cfg.pixel_size == PIX_8) begin
					res.write_enable = !key8;
					res.result_pixel = s & mask;
				end else if (is_16) begin
					res.write_enable = !key16;
					res.result_pixel = key16 ? d : blend16_px;
				end else begin
					res.write_enable = !key32;
					res.result_pixel = key32 ? d : mix_px;
				end
			end
			default: begin
				res.write_enable = 1'b0;
				res.result_pixel = d;
			end
		endcase
	end

endmodule

/* sv/pixel_put_mode_combiner_top.sv */
// Pixel put-mode combiner, top level: input register, combine datapath,
// result register, APB configuration registers.
// Depends on ppmc_pkg, ppmc_apb_regs and ppmc_combine.
// A transaction accepted with start passes through the input register and then the
// result register, where it shows its result with result_valid. Throughput: one transaction
// per cycle, busy is never raised; the path between the input and result registers sets the pace.
// Reset (arst_n low) clears the pipeline valids and loads the register resets.
module pixel_put_mode_combiner_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ppmc_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [ppmc_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [ppmc_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready,
	input  logic                                  start,
	output logic                                  busy,
	input  ppmc_pkg::pix_in_t                     operands,
	output ppmc_pkg::pix_out_t                    result,
	output logic                                  result_valid
);
	import ppmc_pkg::*;

	cfg_t     cfg;
	logic     accept;
	logic     valid_s1, valid_s2;
	pix_in_t  operand_s1;
	pix_out_t comb_res;
	pix_out_t result_s2;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// configuration registers
	ppmc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			operand_s1 <= operands;
		end
	end

	// combine datapath
	ppmc_combine u_combine (
		.cfg     (cfg),
		.operand (operand_s1),
		.res     (comb_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= comb_res;
		end
	end

	assign result       = result_s2;
	assign result_valid = valid_s2;

	// every accepted transaction gives a strobe after the input and result registers
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 result_valid)
		else $error("accepted transaction produced no result");
	// no strobe without an earlier accepted transaction
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(accept, 2))
		else $error("result strobe without a transaction");
	// a held result register keeps its value when no transaction moves
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(result_s2))
		else $error("result register changed without a transaction");

endmodule
